/* sv/fwt_pkg.sv */
`default_nettype none

package fwt_pkg;

  localparam int ENTRIES     = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam int ADDR_W  = 64;
  localparam int TID_W   = 16;
  localparam int LIMIT_W = 31;
  localparam int COUNT_W = 7;

  localparam logic [1:0] CMD_WAIT    = 2'd0;
  localparam logic [1:0] CMD_WAKE    = 2'd1;
  localparam logic [1:0] CMD_REQUEUE = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  localparam logic [1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [1:0] KIND_FULL     = 2'd1;
  localparam logic [1:0] KIND_WOKEN    = 2'd2;
  localparam logic [1:0] KIND_DONE     = 2'd3;

  typedef enum logic [1:0] {
    OP_WAIT,
    OP_WAKE,
    OP_REQUEUE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [ADDR_W-1:0]  wait_address;
    logic [TID_W-1:0]   thread_id;
    logic [LIMIT_W-1:0] wake_limit;
    logic [ADDR_W-1:0]  target_address;
  } fwt_in_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [TID_W-1:0]   woken_thread;
    logic [COUNT_W-1:0] affected_count;
    logic               last;
  } fwt_out_t;

  typedef struct packed {
    op_t                op;
    logic [ADDR_W-1:0]  wait_address;
    logic [TID_W-1:0]   thread_id;
    logic [LIMIT_W-1:0] wake_limit;
    logic [ADDR_W-1:0]  target_address;
  } fwt_job_t;

endpackage

`default_nettype wire

/* sv/fwt_front.sv */
`default_nettype none

module fwt_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire fwt_pkg::fwt_in_t in_data,
  output logic                  job_valid,
  input  wire logic             job_ready,
  output fwt_pkg::fwt_job_t     job
);
  import fwt_pkg::*;

  logic     hold_valid_r;
  logic     hold_valid_nxt;
  fwt_job_t hold_r;
  fwt_job_t hold_nxt;
  logic     accept;
  op_t      op_dec;

  always_comb begin
    unique case (in_data.command)
      CMD_WAIT:    op_dec = OP_WAIT;
      CMD_WAKE:    op_dec = OP_WAKE;
      CMD_REQUEUE: op_dec = OP_REQUEUE;
      CMD_CLEAR:   op_dec = OP_CLEAR;
      default:     op_dec = OP_WAIT;
    endcase
  end

  assign in_stall  = hold_valid_r && !job_ready;
  assign accept    = in_valid && !in_stall;
  assign job_valid = hold_valid_r;
  assign job       = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r && !job_ready;
    hold_nxt       = hold_r;
    if (accept) begin
      hold_valid_nxt          = 1'b1;
      hold_nxt.op             = op_dec;
      hold_nxt.wait_address   = in_data.wait_address;
      hold_nxt.thread_id      = in_data.thread_id;
      hold_nxt.wake_limit     = in_data.wake_limit;
      hold_nxt.target_address = in_data.target_address;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

`default_nettype wire

/* sv/fwt_queue.sv */
`default_nettype none

module fwt_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire fwt_pkg::fwt_job_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop,
  output fwt_pkg::fwt_job_t      pop_data
);
  import fwt_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fwt_job_t         store_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = store_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* sv/fwt_back.sv */
`default_nettype none

module fwt_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  output logic                   job_pop,
  input  wire fwt_pkg::fwt_job_t job_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output fwt_pkg::fwt_out_t      out_data
);
  import fwt_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  fwt_job_t           job_r;
  fwt_job_t           job_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [LIMIT_W-1:0] limit_nxt;
  logic [COUNT_W-1:0] cnt_r;
  logic [COUNT_W-1:0] cnt_nxt;

  logic [ENTRIES-1:0] valid_r;
  logic [ADDR_W-1:0]  addr_r [ENTRIES];
  logic [TID_W-1:0]   thr_r  [ENTRIES];

  logic [ENTRIES-1:0] addr_hit;
  logic [ENTRIES-1:0] thr_hit;
  logic [ENTRIES-1:0] hit;
  logic [ENTRIES-1:0] hit_first;
  logic [ENTRIES-1:0] free;
  logic [ENTRIES-1:0] free_first;
  logic [TID_W-1:0]   sel_thread;

  logic [ENTRIES-1:0] clr_mask;
  logic [ENTRIES-1:0] wr_mask;
  logic [ENTRIES-1:0] rt_mask;

  logic               out_valid_r;
  fwt_out_t           out_r;
  logic               can_emit;
  logic               emit;
  fwt_out_t           emit_data;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign can_emit  = !out_valid_r || !out_stall;

  // match every slot against the held request in parallel
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      addr_hit[i] = valid_r[i] && (addr_r[i] == job_r.wait_address);
      thr_hit[i]  = valid_r[i] && (thr_r[i] == job_r.thread_id);
    end
  end

  assign hit        = (job_r.op == OP_CLEAR) ? thr_hit : addr_hit;
  assign hit_first  = hit & (~hit + ENTRIES'(1));
  assign free       = ~valid_r;
  assign free_first = free & (~free + ENTRIES'(1));

  always_comb begin
    sel_thread = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_thread = sel_thread | ({TID_W{hit_first[i]}} & thr_r[i]);
    end
  end

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    limit_nxt = limit_r;
    cnt_nxt   = cnt_r;
    job_pop   = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    clr_mask  = '0;
    wr_mask   = '0;
    rt_mask   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          job_nxt   = job_data;
          limit_nxt = job_data.wake_limit;
          cnt_nxt   = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (can_emit) begin
          case (job_r.op) inside
            OP_WAIT: begin
              emit           = 1'b1;
              emit_data.last = 1'b1;
              if (|free) begin
                wr_mask        = free_first;
                emit_data.kind = KIND_ACCEPTED;
              end else begin
                emit_data.kind = KIND_FULL;
              end
              state_nxt = ST_IDLE;
            end
            OP_CLEAR: begin
              // drop one matching slot a cycle while the output can take a result, report the total at the end
              if (|hit) begin
                clr_mask = hit_first;
                cnt_nxt  = cnt_r + COUNT_W'(1);
              end else begin
                emit                     = 1'b1;
                emit_data.kind           = KIND_DONE;
                emit_data.affected_count = cnt_r;
                emit_data.last           = 1'b1;
                state_nxt                = ST_IDLE;
              end
            end
            OP_WAKE, OP_REQUEUE: begin
              if ((limit_r != '0) && (|hit)) begin
                clr_mask               = hit_first;
                emit                   = 1'b1;
                emit_data.kind         = KIND_WOKEN;
                emit_data.woken_thread = sel_thread;
                limit_nxt              = limit_r - LIMIT_W'(1);
                cnt_nxt                = cnt_r + COUNT_W'(1);
              end else begin
                emit                     = 1'b1;
                emit_data.kind           = KIND_DONE;
                emit_data.affected_count = cnt_r;
                emit_data.last           = 1'b1;
                if (job_r.op == OP_REQUEUE) begin
                  rt_mask = addr_hit;
                end
                state_nxt = ST_IDLE;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= (valid_r & ~clr_mask) | wr_mask;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    limit_r <= limit_nxt;
    cnt_r   <= cnt_nxt;
    if (emit) begin
      out_r <= emit_data;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_mask[i]) begin
        addr_r[i] <= job_r.wait_address;
        thr_r[i]  <= job_r.thread_id;
      end else if (rt_mask[i]) begin
        addr_r[i] <= job_r.target_address;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/futex_wait_table.sv */
// A request is registered in the front end, queued, then held in the back end;
// results are registered at the output. Wake and requeue wake, and clear drops,
// one matching slot per cycle while the output can accept; then requeue moves
// the rest at once. A two-entry queue lets the front end take requests meanwhile.
// Reset: synchronous, active low; every slot is marked free at once, no sweep.
`default_nettype none

module futex_wait_table (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire fwt_pkg::fwt_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output fwt_pkg::fwt_out_t     out_data
);
  import fwt_pkg::*;

  logic     fr_valid;
  logic     fr_ready;
  fwt_job_t fr_job;
  logic     q_valid;
  logic     q_pop;
  fwt_job_t q_job;

  fwt_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  fwt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_job),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_job)
  );

  fwt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job_pop   (q_pop),
    .job_data  (q_job),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

/* sim/futex_wait_table_checker.sv */
module futex_wait_table_checker
  import fwt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  fwt_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  fwt_out_t out_data,
  output int       mismatch_count,
  output int       results_due,
  output int       results_checked,
  output int       threads_woken,
  output int       full_refusals
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PRINTED = 30;

  // Shadow of the wait table
  logic              slot_busy  [ENTRIES];
  logic [ADDR_W-1:0] slot_addr  [ENTRIES];
  logic [TID_W-1:0]  slot_owner [ENTRIES];

  fwt_out_t due_results[$];
  fwt_out_t want;
  int       mismatches = 0;
  int       checked    = 0;
  int       woken      = 0;
  int       refusals   = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("[%0t] mismatch: %s", $time, what);
    end
  endtask

  function automatic fwt_out_t make_result(input logic [1:0] kind,
                                           input logic [TID_W-1:0] tid,
                                           input logic [COUNT_W-1:0] affected,
                                           input logic last);
    fwt_out_t res;
    res.kind           = kind;
    res.woken_thread   = tid;
    res.affected_count = affected;
    res.last           = last;
    return res;
  endfunction

  // Wake matching waiters in slot order until the limit runs out
  function automatic void wake_waiters(input logic [ADDR_W-1:0] addr,
                                       input logic [LIMIT_W-1:0] limit);
    logic [LIMIT_W-1:0] budget = limit;
    int                 count  = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (budget != '0 && slot_busy[i] && slot_addr[i] == addr) begin
        slot_busy[i] = 1'b0;
        due_results.push_back(make_result(KIND_WOKEN, slot_owner[i], '0, 1'b0));
        count++;
        budget = budget - 1'b1;
      end
    end
    due_results.push_back(make_result(KIND_DONE, '0, COUNT_W'(count), 1'b1));
  endfunction

  function automatic void apply_command(input fwt_in_t req);
    int free_slot = -1;
    int cleared   = 0;
    case (req.command)
      CMD_WAIT: begin
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!slot_busy[i]) free_slot = i;
        end
        if (free_slot < 0) begin
          due_results.push_back(make_result(KIND_FULL, '0, '0, 1'b1));
        end else begin
          slot_busy[free_slot]  = 1'b1;
          slot_addr[free_slot]  = req.wait_address;
          slot_owner[free_slot] = req.thread_id;
          due_results.push_back(make_result(KIND_ACCEPTED, '0, '0, 1'b1));
        end
      end
      CMD_WAKE: begin
        wake_waiters(req.wait_address, req.wake_limit);
      end
      CMD_REQUEUE: begin
        wake_waiters(req.wait_address, req.wake_limit);
        // move whatever is still waiting on the old address
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_busy[i] && slot_addr[i] == req.wait_address) begin
            slot_addr[i] = req.target_address;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_busy[i] && slot_owner[i] == req.thread_id) begin
            slot_busy[i] = 1'b0;
            cleared++;
          end
        end
        due_results.push_back(make_result(KIND_DONE, '0, COUNT_W'(cleared), 1'b1));
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (slot_busy[i]) slot_busy[i] = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d thread=%h count=%0d last=%b",
                                    out_data.kind, out_data.woken_thread,
                                    out_data.affected_count, out_data.last));
        end else begin
          want = due_results.pop_front();
          checked++;
          if (want.kind == KIND_WOKEN) woken++;
          if (want.kind == KIND_FULL) refusals++;
          if (out_data.kind !== want.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", out_data.kind, want.kind));
          end
          if (out_data.woken_thread !== want.woken_thread) begin
            report_mismatch($sformatf("woken_thread %h, expected %h",
                                      out_data.woken_thread, want.woken_thread));
          end
          if (out_data.affected_count !== want.affected_count) begin
            report_mismatch($sformatf("affected_count %0d, expected %0d",
                                      out_data.affected_count, want.affected_count));
          end
          if (out_data.last !== want.last) begin
            report_mismatch($sformatf("last %b, expected %b", out_data.last, want.last));
          end
        end
      end
      if (in_valid && !in_stall) apply_command(in_data);
    end
    mismatch_count  <= mismatches;
    results_due     <= due_results.size();
    results_checked <= checked;
    threads_woken   <= woken;
    full_refusals   <= refusals;
  end

endmodule

/* sim/futex_wait_table_test.sv */
module futex_wait_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fwt_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int RANDOM_ITEMS   = 410;
  localparam int IDLE_PERCENT   = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int POOL           = 5;

  localparam logic [ADDR_W-1:0] ADDR_HI  = '1;
  localparam logic [ADDR_W-1:0] ADDR_LO  = '0;
  localparam logic [ADDR_W-1:0] ADDR_MID = 64'h0123_4567_89AB_CDEF;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  fwt_in_t  in_data   = '0;
  logic     out_stall = 1'b0;
  logic     steady    = 1'b0;
  logic     in_stall;
  logic     out_valid;
  fwt_out_t out_data;

  int mismatch_count;
  int results_due;
  int results_checked;
  int threads_woken;
  int full_refusals;
  int requests_sent = 0;
  int idle_cycles   = 0;

  logic [ADDR_W-1:0] address_pool [POOL];
  logic [TID_W-1:0]  thread_pool  [POOL];

  always #(HALF_PERIOD) clk = ~clk;

  futex_wait_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  futex_wait_table_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatch_count  (mismatch_count),
    .results_due     (results_due),
    .results_checked (results_checked),
    .threads_woken   (threads_woken),
    .full_refusals   (full_refusals)
  );

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < IDLE_PERCENT);
    end
  end

  // Give up once neither channel has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic fwt_in_t make_request(input logic [1:0] cmd,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [TID_W-1:0] tid,
                                           input logic [LIMIT_W-1:0] limit,
                                           input logic [ADDR_W-1:0] target);
    fwt_in_t req;
    req.command        = cmd;
    req.wait_address   = addr;
    req.thread_id      = tid;
    req.wake_limit     = limit;
    req.target_address = target;
    return req;
  endfunction

  // Mostly a handful of shared addresses so that waits and wakes meet
  function automatic logic [ADDR_W-1:0] pick_address();
    if ($urandom_range(99) < 85) return address_pool[$urandom_range(POOL - 1)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [TID_W-1:0] pick_thread();
    if ($urandom_range(99) < 80) return thread_pool[$urandom_range(POOL - 1)];
    return TID_W'($urandom);
  endfunction

  function automatic logic [LIMIT_W-1:0] pick_limit();
    int roll = $urandom_range(99);
    if (roll < 55) return LIMIT_W'($urandom_range(3));
    if (roll < 80) return LIMIT_W'($urandom_range(ENTRIES + 1, 4));
    if (roll < 95) return LIMIT_W'($urandom);
    return '1;
  endfunction

  // Hold the request until it is taken; leave valid high for the next one
  task automatic send_request(input fwt_in_t req);
    int gap = 0;
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PERCENT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  initial begin
    int                roll;
    int                sent_random;
    int                directed_sent;
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] burst_addr;

    address_pool[0] = ADDR_LO;
    address_pool[1] = ADDR_HI;
    thread_pool[0]  = '0;
    thread_pool[1]  = '1;
    for (int i = 2; i < POOL; i++) begin
      address_pool[i] = {$urandom, $urandom};
      thread_pool[i]  = TID_W'($urandom);
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // empty table: clear of an absent thread, wake with nothing waiting
    send_request(make_request(CMD_CLEAR, ADDR_LO, '1, '0, ADDR_LO));
    send_request(make_request(CMD_WAKE, ADDR_HI, '0, '1, ADDR_HI));
    // fill every slot, two threads each waiting in several slots
    for (int i = 0; i < ENTRIES; i++) begin
      send_request(make_request(CMD_WAIT,
                                (i % 3 == 0) ? ADDR_HI : (i % 3 == 1) ? ADDR_LO : ADDR_MID,
                                (i < 4) ? 16'hFFFF : (i < 6) ? 16'h0000 : TID_W'(16'h0100 + i),
                                '0, '0));
    end
    send_request(make_request(CMD_WAIT, ADDR_MID, 16'h1234, '1, '1));
    // zero limit moves every match; then a requeue onto its own address
    send_request(make_request(CMD_REQUEUE, ADDR_LO, '0, '0, ADDR_MID));
    send_request(make_request(CMD_REQUEUE, ADDR_MID, '0, LIMIT_W'(2), ADDR_MID));
    send_request(make_request(CMD_WAKE, ADDR_HI, '0, LIMIT_W'(1), '0));
    send_request(make_request(CMD_CLEAR, '0, 16'hFFFF, '0, '0));
    send_request(make_request(CMD_REQUEUE, ADDR_HI, '0, '1, ADDR_LO));
    send_request(make_request(CMD_WAKE, ADDR_MID, '0, '1, '0));
    directed_sent = requests_sent;

    sent_random = 0;
    while (sent_random < RANDOM_ITEMS) begin
      steady <= (sent_random >= 150 && sent_random < 260);
      roll = $urandom_range(99);
      if (roll < 3) begin
        // overfill the table on one address, then wake some of it
        burst_addr = pick_address();
        repeat (ENTRIES + 2) begin
          send_request(make_request(CMD_WAIT, burst_addr, pick_thread(), pick_limit(),
                                    pick_address()));
        end
        send_request(make_request(CMD_WAKE, burst_addr, pick_thread(), pick_limit(),
                                  pick_address()));
        sent_random += ENTRIES + 3;
      end else begin
        cmd = (roll < 45) ? CMD_WAIT : (roll < 65) ? CMD_WAKE :
              (roll < 85) ? CMD_REQUEUE : CMD_CLEAR;
        send_request(make_request(cmd, pick_address(), pick_thread(), pick_limit(),
                                  pick_address()));
        sent_random++;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d directed, %0d random), idling and stalling at random.",
             requests_sent, directed_sent, requests_sent - directed_sent);
    $display("Checked %0d results: %0d threads woken, %0d waits refused on a full table.",
             results_checked, threads_woken, full_refusals);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
sv/fwt_pkg.sv
sv/fwt_front.sv
sv/fwt_queue.sv
sv/fwt_back.sv
sv/futex_wait_table.sv
sim/futex_wait_table_checker.sv
sim/futex_wait_table_test.sv
